>>> rtl/cpu8x_pkg.sv
// ----------------------------------------------------------------------------
// cpu8x_pkg
// Types, opcodes and flag positions for the 8-bit execute unit.
// ----------------------------------------------------------------------------
package cpu8x_pkg;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  operand_value;
    logic [15:0] jump_target;
    logic [15:0] pc_next;
  } cpu8x_in_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  status;
    logic [7:0]  stack_ptr;
    logic [15:0] next_pc;
    logic        mem_write;
    logic        to_stack;
    logic [15:0] write_data;
    logic [1:0]  write_bytes;
  } cpu8x_out_t;

  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [7:0] P_RESET    = 8'h34;
  localparam logic [7:0] SP_RESET   = 8'hFD;
  localparam logic [7:0] P_BRK_MASK = 8'h30;

  localparam logic [1:0] GRP_ONE = 2'b01;

  localparam logic [2:0] GRP_ORA = 3'd0;
  localparam logic [2:0] GRP_AND = 3'd1;
  localparam logic [2:0] GRP_EOR = 3'd2;
  localparam logic [2:0] GRP_ADC = 3'd3;
  localparam logic [2:0] GRP_STA = 3'd4;
  localparam logic [2:0] GRP_LDA = 3'd5;
  localparam logic [2:0] GRP_CMP = 3'd6;
  localparam logic [2:0] GRP_SBC = 3'd7;

  localparam logic [1:0] WB_NONE = 2'd0;
  localparam logic [1:0] WB_ONE  = 2'd1;
  localparam logic [1:0] WB_TWO  = 2'd2;

  localparam logic [7:0] OP_NOP_IMM  = 8'h89;
  localparam logic [7:0] OP_PHP      = 8'h08;
  localparam logic [7:0] OP_PHA      = 8'h48;
  localparam logic [7:0] OP_JSR      = 8'h20;
  localparam logic [7:0] OP_PLP      = 8'h28;
  localparam logic [7:0] OP_PLA      = 8'h68;
  localparam logic [7:0] OP_RTI      = 8'h40;
  localparam logic [7:0] OP_RTS      = 8'h60;
  localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
  localparam logic [7:0] OP_JMP_IND  = 8'h6C;
  localparam logic [7:0] OP_BPL      = 8'h10;
  localparam logic [7:0] OP_BMI      = 8'h30;
  localparam logic [7:0] OP_BVC      = 8'h50;
  localparam logic [7:0] OP_BVS      = 8'h70;
  localparam logic [7:0] OP_BCC      = 8'h90;
  localparam logic [7:0] OP_BCS      = 8'hB0;
  localparam logic [7:0] OP_BNE      = 8'hD0;
  localparam logic [7:0] OP_BEQ      = 8'hF0;
  localparam logic [7:0] OP_CLC      = 8'h18;
  localparam logic [7:0] OP_SEC      = 8'h38;
  localparam logic [7:0] OP_CLI      = 8'h58;
  localparam logic [7:0] OP_SEI      = 8'h78;
  localparam logic [7:0] OP_CLV      = 8'hB8;
  localparam logic [7:0] OP_CLD      = 8'hD8;
  localparam logic [7:0] OP_SED      = 8'hF8;
  localparam logic [7:0] OP_BIT_ZP   = 8'h24;
  localparam logic [7:0] OP_BIT_ABS  = 8'h2C;
  localparam logic [7:0] OP_STY_ZP   = 8'h84;
  localparam logic [7:0] OP_STY_ABS  = 8'h8C;
  localparam logic [7:0] OP_STY_ZPX  = 8'h94;
  localparam logic [7:0] OP_DEY      = 8'h88;
  localparam logic [7:0] OP_INY      = 8'hC8;
  localparam logic [7:0] OP_INX      = 8'hE8;
  localparam logic [7:0] OP_TYA      = 8'h98;
  localparam logic [7:0] OP_TAY      = 8'hA8;
  localparam logic [7:0] OP_LDY_IMM  = 8'hA0;
  localparam logic [7:0] OP_LDY_ZP   = 8'hA4;
  localparam logic [7:0] OP_LDY_ABS  = 8'hAC;
  localparam logic [7:0] OP_LDY_ZPX  = 8'hB4;
  localparam logic [7:0] OP_LDY_ABX  = 8'hBC;
  localparam logic [7:0] OP_CPY_IMM  = 8'hC0;
  localparam logic [7:0] OP_CPY_ZP   = 8'hC4;
  localparam logic [7:0] OP_CPY_ABS  = 8'hCC;
  localparam logic [7:0] OP_CPX_IMM  = 8'hE0;
  localparam logic [7:0] OP_CPX_ZP   = 8'hE4;
  localparam logic [7:0] OP_CPX_ABS  = 8'hEC;

  function automatic logic [7:0] put_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r       = p;
    r[FL_Z] = (v == 8'h00);
    r[FL_N] = v[7];
    return r;
  endfunction

endpackage

>>> rtl/cpu_8bit_execute_unit_top.sv
// ----------------------------------------------------------------------------
// cpu_8bit_execute_unit_top
// Execute stage of an 8-bit accumulator CPU with A, X, Y, flags and SP.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one decoded instruction
//   word: opcode, operand byte, resolved target and sequential PC.
//   Output channel (out_valid/out_ready/out_data) returns one result word per
//   instruction: the register file after it, the next PC and at most one write
//   request (store or stack push).
//   The result word appears in the cycle after the instruction word is
//   taken. Throughput: one instruction per cycle while out_ready holds;
//   the combinational ALU, compare and flag logic feed the architectural registers.
//   The result register decouples the sides: a new word is taken whenever
//   the result register is empty or its word leaves in the same cycle.
//   A stalled receiver holds the result word and at once pulls in_ready low.
//   Reset: A, X, Y cleared, flags 0x34, stack pointer 0xFD, no result held.
// ----------------------------------------------------------------------------
module cpu_8bit_execute_unit_top
  import cpu8x_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cpu8x_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cpu8x_out_t out_data
);

  logic [7:0]  acc_r, x_r, y_r, p_r, sp_r;
  logic [7:0]  acc_nxt, x_nxt, y_nxt, p_nxt, sp_nxt;
  logic        out_valid_r;
  cpu8x_out_t  out_data_r;
  cpu8x_out_t  res_nxt;

  logic [7:0]  op, m;
  logic [7:0]  adc_src, adc_res, cmp_reg;
  logic [8:0]  adc_sum, cmp_diff;
  logic        adc_v, br_flag, br_taken;
  logic [15:0] npc;
  logic        wr, stk;
  logic [15:0] wdata;
  logic [1:0]  wbytes;
  logic        accept;

  assign op       = in_data.opcode;
  assign m        = in_data.operand_value;
  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign adc_src = (op[7:5] == GRP_SBC) ? ~m : m;
  assign adc_sum = {1'b0, acc_r} + {1'b0, adc_src} + {8'h00, p_r[FL_C]};
  assign adc_res = adc_sum[7:0];
  assign adc_v   = ~(acc_r[7] ^ adc_src[7]) & (acc_r[7] ^ adc_res[7]);

  assign cmp_reg  = (op[1:0] == GRP_ONE) ? acc_r : (op[5] ? x_r : y_r);
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};

  always_comb begin
    case (op[7:6])
      2'b00:   br_flag = p_r[FL_N];
      2'b01:   br_flag = p_r[FL_V];
      2'b10:   br_flag = p_r[FL_C];
      default: br_flag = p_r[FL_Z];
    endcase
  end
  assign br_taken = (br_flag == op[5]);

  always_comb begin
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    p_nxt   = p_r;
    sp_nxt  = sp_r;
    npc     = in_data.pc_next;
    wr      = 1'b0;
    stk     = 1'b0;
    wdata   = 16'h0000;
    wbytes  = WB_NONE;
    if (op[1:0] == GRP_ONE) begin
      case (op[7:5])
        GRP_ORA: begin
          acc_nxt = acc_r | m;
          p_nxt   = put_nz(p_r, acc_r | m);
        end
        GRP_AND: begin
          acc_nxt = acc_r & m;
          p_nxt   = put_nz(p_r, acc_r & m);
        end
        GRP_EOR: begin
          acc_nxt = acc_r ^ m;
          p_nxt   = put_nz(p_r, acc_r ^ m);
        end
        GRP_STA: begin
          if (op != OP_NOP_IMM) begin
            wr     = 1'b1;
            wdata  = {8'h00, acc_r};
            wbytes = WB_ONE;
          end
        end
        GRP_LDA: begin
          acc_nxt = m;
          p_nxt   = put_nz(p_r, m);
        end
        GRP_CMP: begin
          p_nxt       = put_nz(p_r, cmp_diff[7:0]);
          p_nxt[FL_C] = !cmp_diff[8];
        end
        default: begin
          acc_nxt     = adc_res;
          p_nxt       = put_nz(p_r, adc_res);
          p_nxt[FL_C] = adc_sum[8];
          p_nxt[FL_V] = adc_v;
        end
      endcase
    end else begin
      case (op)
        OP_PHP: begin
          wr     = 1'b1;
          stk    = 1'b1;
          wbytes = WB_ONE;
          wdata  = {8'h00, p_r | P_BRK_MASK};
          sp_nxt = sp_r - 8'd1;
        end
        OP_PHA: begin
          wr     = 1'b1;
          stk    = 1'b1;
          wbytes = WB_ONE;
          wdata  = {8'h00, acc_r};
          sp_nxt = sp_r - 8'd1;
        end
        OP_JSR: begin
          wr     = 1'b1;
          stk    = 1'b1;
          wbytes = WB_TWO;
          wdata  = in_data.pc_next - 16'd1;
          sp_nxt = sp_r - 8'd2;
          npc    = in_data.jump_target;
        end
        OP_PLP: begin
          p_nxt  = (m & ~P_BRK_MASK) | (p_r & P_BRK_MASK);
          sp_nxt = sp_r + 8'd1;
        end
        OP_PLA: begin
          acc_nxt = m;
          p_nxt   = put_nz(p_r, m);
          sp_nxt  = sp_r + 8'd1;
        end
        OP_RTI: begin
          p_nxt  = (m & ~P_BRK_MASK) | (p_r & P_BRK_MASK);
          sp_nxt = sp_r + 8'd3;
          npc    = in_data.jump_target;
        end
        OP_RTS: begin
          sp_nxt = sp_r + 8'd2;
          npc    = in_data.jump_target + 16'd1;
        end
        OP_JMP_ABS, OP_JMP_IND: npc = in_data.jump_target;
        OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ: begin
          if (br_taken) npc = in_data.jump_target;
        end
        OP_CLC: p_nxt[FL_C] = 1'b0;
        OP_SEC: p_nxt[FL_C] = 1'b1;
        OP_CLI: p_nxt[FL_I] = 1'b0;
        OP_SEI: p_nxt[FL_I] = 1'b1;
        OP_CLV: p_nxt[FL_V] = 1'b0;
        OP_CLD: p_nxt[FL_D] = 1'b0;
        OP_SED: p_nxt[FL_D] = 1'b1;
        OP_BIT_ZP, OP_BIT_ABS: begin
          p_nxt[FL_Z] = ((acc_r & m) == 8'h00);
          p_nxt[FL_V] = m[6];
          p_nxt[FL_N] = m[7];
        end
        OP_STY_ZP, OP_STY_ABS, OP_STY_ZPX: begin
          wr     = 1'b1;
          wbytes = WB_ONE;
          wdata  = {8'h00, y_r};
        end
        OP_DEY: begin
          y_nxt = y_r - 8'd1;
          p_nxt = put_nz(p_r, y_r - 8'd1);
        end
        OP_INY: begin
          y_nxt = y_r + 8'd1;
          p_nxt = put_nz(p_r, y_r + 8'd1);
        end
        OP_INX: begin
          x_nxt = x_r + 8'd1;
          p_nxt = put_nz(p_r, x_r + 8'd1);
        end
        OP_TYA: begin
          acc_nxt = y_r;
          p_nxt   = put_nz(p_r, y_r);
        end
        OP_TAY: begin
          y_nxt = acc_r;
          p_nxt = put_nz(p_r, acc_r);
        end
        OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_LDY_ZPX, OP_LDY_ABX: begin
          y_nxt = m;
          p_nxt = put_nz(p_r, m);
        end
        OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS, OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS: begin
          p_nxt       = put_nz(p_r, cmp_diff[7:0]);
          p_nxt[FL_C] = !cmp_diff[8];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt.acc         = acc_nxt;
    res_nxt.index_x     = x_nxt;
    res_nxt.index_y     = y_nxt;
    res_nxt.status      = p_nxt;
    res_nxt.stack_ptr   = sp_nxt;
    res_nxt.next_pc     = npc;
    res_nxt.mem_write   = wr;
    res_nxt.to_stack    = stk;
    res_nxt.write_data  = wdata;
    res_nxt.write_bytes = wbytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 8'h00;
      x_r         <= 8'h00;
      y_r         <= 8'h00;
      p_r         <= P_RESET;
      sp_r        <= SP_RESET;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      acc_r       <= acc_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      p_r         <= p_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/cpu8x_checker.sv
// ----------------------------------------------------------------------------
// cpu8x_checker
// Port-level checks for the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module cpu8x_checker
  import cpu8x_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input cpu8x_out_t out_data
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  a_no_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mem_write |->
      out_data.write_bytes == WB_NONE && !out_data.to_stack &&
      out_data.write_data == 16'h0000)
    else $error("write fields set without a write");

  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mem_write |->
      (out_data.write_bytes == WB_ONE || out_data.write_bytes == WB_TWO))
    else $error("write without byte count");

endmodule

bind cpu_8bit_execute_unit_top cpu8x_checker u_cpu8x_checker (.*);

>>> bench/cpu_8bit_execute_unit_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_8bit_execute_unit_top_test
// Self-checking bench for the 8-bit CPU execute stage.
//
// A directed opening walks the flag, carry, overflow, compare, branch and
// stack corner cases, then about 1700 random instruction words follow, mostly
// defined opcodes with biased operands. A shadow copy of A, X, Y, flags and
// SP predicts every result word, which is checked field by field in order.
// The sender runs in random bursts, the receiver stalls on its own pattern
// and once holds off long enough to back up the input channel.
// ----------------------------------------------------------------------------
module cpu_8bit_execute_unit_top_test;
  import cpu8x_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 1700;
  localparam int HOLD_CYCLES    = 200;
  localparam logic [2:0] AM_IMM = 3'b010;
  localparam logic [7:0] OP_NOP = 8'hEA;
  localparam logic [7:0] OP_LDA_IMM = {GRP_LDA, AM_IMM, GRP_ONE};
  localparam logic [7:0] OP_ADC_IMM = {GRP_ADC, AM_IMM, GRP_ONE};
  localparam logic [7:0] OP_SBC_IMM = {GRP_SBC, AM_IMM, GRP_ONE};
  localparam logic [7:0] OP_CMP_IMM = {GRP_CMP, AM_IMM, GRP_ONE};
  localparam logic [7:0] NAMED_OPS [46] = '{
    OP_PHP, OP_PHA, OP_JSR, OP_PLP, OP_PLA, OP_RTI, OP_RTS, OP_JMP_ABS, OP_JMP_IND,
    OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ,
    OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD, OP_SED,
    OP_BIT_ZP, OP_BIT_ABS, OP_STY_ZP, OP_STY_ABS, OP_STY_ZPX,
    OP_DEY, OP_INY, OP_INX, OP_TYA, OP_TAY,
    OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_LDY_ZPX, OP_LDY_ABX,
    OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS, OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS,
    OP_NOP_IMM
  };
  localparam logic [7:0] EDGE_BYTES [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};

  typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  cpu8x_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  cpu8x_out_t out_data;

  cpu8x_in_t  pending_words[$];
  cpu8x_out_t expected_results[$];

  logic [7:0] a_q, x_q, y_q, p_q, sp_q;
  logic [255:0] op_seen = '0;
  int branches_taken = 0;
  int words_in = 0;
  int fail_count = 0;
  int results_seen = 0;
  int burst_left, gap_left, hold_left, idle_cycles;
  logic hold_done;
  logic [7:0] rx_phase;
  rx_mode_e rx_mode;

  cpu_8bit_execute_unit_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void set_zn(input logic [7:0] v);
    p_q[FL_Z] = (v == 8'h00);
    p_q[FL_N] = v[7];
  endfunction

  function automatic void add_carry(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, a_q} + {1'b0, m} + {8'h00, p_q[FL_C]};
    p_q[FL_C] = sum[8];
    p_q[FL_V] = ~(a_q[7] ^ m[7]) & (a_q[7] ^ sum[7]);
    a_q = sum[7:0];
    set_zn(a_q);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    p_q[FL_C] = (r >= m);
    set_zn(r - m);
  endfunction

  function automatic cpu8x_out_t execute_insn(input cpu8x_in_t w);
    cpu8x_out_t r;
    logic [7:0] m;
    logic take;
    r = '0;
    m = w.operand_value;
    take = 1'b0;
    r.next_pc = w.pc_next;
    op_seen[w.opcode] = 1'b1;
    if (w.opcode[1:0] == GRP_ONE) begin
      case (w.opcode[7:5])
        GRP_ORA: begin a_q = a_q | m; set_zn(a_q); end
        GRP_AND: begin a_q = a_q & m; set_zn(a_q); end
        GRP_EOR: begin a_q = a_q ^ m; set_zn(a_q); end
        GRP_ADC: add_carry(m);
        GRP_STA: begin
          if (w.opcode != OP_NOP_IMM) begin
            r.mem_write = 1'b1;
            r.write_data = {8'h00, a_q};
            r.write_bytes = WB_ONE;
          end
        end
        GRP_LDA: begin a_q = m; set_zn(m); end
        GRP_CMP: compare_reg(a_q, m);
        default: add_carry(~m);
      endcase
    end else begin
      case (w.opcode)
        OP_PHP, OP_PHA: begin
          r.mem_write = 1'b1;
          r.to_stack = 1'b1;
          r.write_bytes = WB_ONE;
          r.write_data = {8'h00, (w.opcode == OP_PHP) ? (p_q | P_BRK_MASK) : a_q};
          sp_q = sp_q - 8'd1;
        end
        OP_JSR: begin
          r.mem_write = 1'b1;
          r.to_stack = 1'b1;
          r.write_bytes = WB_TWO;
          r.write_data = w.pc_next - 16'd1;
          sp_q = sp_q - 8'd2;
          r.next_pc = w.jump_target;
        end
        OP_PLP: begin
          p_q = (m & ~P_BRK_MASK) | (p_q & P_BRK_MASK);
          sp_q = sp_q + 8'd1;
        end
        OP_PLA: begin a_q = m; set_zn(m); sp_q = sp_q + 8'd1; end
        OP_RTI: begin
          p_q = (m & ~P_BRK_MASK) | (p_q & P_BRK_MASK);
          sp_q = sp_q + 8'd3;
          r.next_pc = w.jump_target;
        end
        OP_RTS: begin sp_q = sp_q + 8'd2; r.next_pc = w.jump_target + 16'd1; end
        OP_JMP_ABS, OP_JMP_IND: r.next_pc = w.jump_target;
        OP_BPL: take = !p_q[FL_N];
        OP_BMI: take = p_q[FL_N];
        OP_BVC: take = !p_q[FL_V];
        OP_BVS: take = p_q[FL_V];
        OP_BCC: take = !p_q[FL_C];
        OP_BCS: take = p_q[FL_C];
        OP_BNE: take = !p_q[FL_Z];
        OP_BEQ: take = p_q[FL_Z];
        OP_CLC: p_q[FL_C] = 1'b0;
        OP_SEC: p_q[FL_C] = 1'b1;
        OP_CLI: p_q[FL_I] = 1'b0;
        OP_SEI: p_q[FL_I] = 1'b1;
        OP_CLV: p_q[FL_V] = 1'b0;
        OP_CLD: p_q[FL_D] = 1'b0;
        OP_SED: p_q[FL_D] = 1'b1;
        OP_BIT_ZP, OP_BIT_ABS: begin
          p_q[FL_Z] = ((a_q & m) == 8'h00);
          p_q[FL_V] = m[6];
          p_q[FL_N] = m[7];
        end
        OP_STY_ZP, OP_STY_ABS, OP_STY_ZPX: begin
          r.mem_write = 1'b1;
          r.write_data = {8'h00, y_q};
          r.write_bytes = WB_ONE;
        end
        OP_DEY: begin y_q = y_q - 8'd1; set_zn(y_q); end
        OP_INY: begin y_q = y_q + 8'd1; set_zn(y_q); end
        OP_INX: begin x_q = x_q + 8'd1; set_zn(x_q); end
        OP_TYA: begin a_q = y_q; set_zn(a_q); end
        OP_TAY: begin y_q = a_q; set_zn(y_q); end
        OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_LDY_ZPX, OP_LDY_ABX: begin
          y_q = m;
          set_zn(m);
        end
        OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS: compare_reg(y_q, m);
        OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS: compare_reg(x_q, m);
        default: ;
      endcase
      if (take) begin
        r.next_pc = w.jump_target;
        branches_taken++;
      end
    end
    r.acc = a_q;
    r.index_x = x_q;
    r.index_y = y_q;
    r.status = p_q;
    r.stack_ptr = sp_q;
    return r;
  endfunction

  task automatic add_word(input logic [7:0] op, input logic [7:0] m,
                          input logic [15:0] tgt, input logic [15:0] pcn);
    cpu8x_in_t w;
    w.opcode = op;
    w.operand_value = m;
    w.jump_target = tgt;
    w.pc_next = pcn;
    pending_words.push_back(w);
  endtask

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // driver: hold the word until taken, advance in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= $urandom_range(1, 48);
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0 || pending_words.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
        if (burst_left == 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_phase <= '0;
      rx_mode <= RX_OPEN;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 8'd1;
      if (rx_phase[5:0] == 6'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 400) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_BUSY:   out_ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 3);
          default:   out_ready <= rx_phase[1];
        endcase
      end
    end
  end

  // monitor: predict on input words, check result words in order
  always @(posedge clk) begin
    cpu8x_out_t want;
    string bad;
    if (!rst_n) begin
      a_q = 8'h00;
      x_q = 8'h00;
      y_q = 8'h00;
      p_q = P_RESET;
      sp_q = SP_RESET;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(execute_insn(in_data));
        words_in++;
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result word %p", out_data);
        end else begin
          want = expected_results.pop_front();
          bad = "";
          if (out_data.acc !== want.acc) bad = {bad, " acc"};
          if (out_data.index_x !== want.index_x) bad = {bad, " index_x"};
          if (out_data.index_y !== want.index_y) bad = {bad, " index_y"};
          if (out_data.status !== want.status) bad = {bad, " status"};
          if (out_data.stack_ptr !== want.stack_ptr) bad = {bad, " stack_ptr"};
          if (out_data.next_pc !== want.next_pc) bad = {bad, " next_pc"};
          if (out_data.mem_write !== want.mem_write) bad = {bad, " mem_write"};
          if (out_data.to_stack !== want.to_stack) bad = {bad, " to_stack"};
          if (out_data.write_data !== want.write_data) bad = {bad, " write_data"};
          if (out_data.write_bytes !== want.write_bytes) bad = {bad, " write_bytes"};
          if (bad != "") begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch on result %0d:%s\n  expected %p\n  actual   %p",
                       results_seen, bad, want, out_data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    logic [7:0] op;
    logic [7:0] m;
    add_word(OP_NOP, 8'h00, 16'h0000, 16'h0000);
    add_word(OP_LDA_IMM, 8'h80, 16'hFFFF, 16'hFFFF);
    add_word(OP_ADC_IMM, 8'h80, 16'h1111, 16'h0002);
    add_word(OP_BCS, 8'h00, 16'hFFFF, 16'h1234);
    add_word(OP_CLC, 8'hFF, 16'h0000, 16'h0004);
    add_word(OP_BCC, 8'h00, 16'h0000, 16'h4321);
    add_word(OP_LDA_IMM, 8'h7F, 16'h2222, 16'h0006);
    add_word(OP_ADC_IMM, 8'h01, 16'h3333, 16'h0008);
    add_word(OP_BVS, 8'h00, 16'h8000, 16'h7FFF);
    add_word(OP_SEC, 8'h00, 16'h4444, 16'h000A);
    add_word(OP_SBC_IMM, 8'h01, 16'h5555, 16'h000C);
    add_word(OP_CMP_IMM, 8'h7F, 16'h6666, 16'h000E);
    add_word(OP_CMP_IMM, 8'hFF, 16'h7777, 16'h0010);
    add_word(OP_INX, 8'h00, 16'h8888, 16'h0011);
    add_word(OP_CPX_IMM, 8'h00, 16'h9999, 16'h0013);
    add_word(OP_DEY, 8'h00, 16'hAAAA, 16'h0014);
    add_word(OP_CPY_IMM, 8'hFF, 16'hBBBB, 16'h0016);
    add_word(OP_BIT_ZP, 8'hC0, 16'hCCCC, 16'h0018);
    add_word(OP_PHP, 8'h00, 16'hDDDD, 16'h0019);
    add_word(OP_PLP, 8'hFF, 16'hEEEE, 16'h001A);
    add_word(OP_JSR, 8'h00, 16'hC000, 16'h0000);
    add_word(OP_RTS, 8'h00, 16'hFFFF, 16'hC001);
    add_word(OP_RTI, 8'h00, 16'hABCD, 16'h0001);
    add_word(OP_PHA, 8'h55, 16'h1357, 16'hABCE);
    add_word(OP_NOP_IMM, 8'hFF, 16'hFFFF, 16'hABD0);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) op = {3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), GRP_ONE};
      else if (pick < 85) op = NAMED_OPS[$urandom_range(0, 45)];
      else op = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) m = EDGE_BYTES[$urandom_range(0, 4)];
      else m = 8'($urandom_range(0, 255));
      add_word(op, m, pick_addr(), pick_addr());
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    $display("Ran %0d instruction words and %0d result words through the execute unit",
             words_in, results_seen);
    $display("Opcodes exercised: %0d of 256, taken branches: %0d, long receiver hold: %0d",
             $countones(op_seen), branches_taken, hold_done);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cpu8x_pkg.sv
rtl/cpu_8bit_execute_unit_top.sv
rtl/cpu8x_checker.sv
bench/cpu_8bit_execute_unit_top_test.sv
